// ===== hw/rtl/bounded_list_table_engine_top_assert.svh =====
// ----------------------------------------------------------------------------
// Bounded list table engine assertion macros
// Concurrent assertion wrappers; ASSERT_OFF removes them all.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_TABLE_ENGINE_TOP_ASSERT_SVH
`define BOUNDED_LIST_TABLE_ENGINE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// checked on the rising edge of clock, held off during reset
`define BLTE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked on every rising edge of clock, reset included
`define BLTE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define BLTE_ASSERT(lbl, prop, msg)
`define BLTE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/blte_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded list table engine package
// Command and status codes, controller states and control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blte_pkg;

   localparam int NUM_BINS_DEF  = 8;
   localparam int BIN_DEPTH_DEF = 8;

   localparam int CMD_W    = 4;
   localparam int BIN_F_W  = 4;
   localparam int AMOUNT_W = 6;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 4;
   localparam int COUNT_W  = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE     = 4'd0,
      CMD_APPEND     = 4'd1,
      CMD_DROP       = 4'd2,
      CMD_REMOVE     = 4'd3,
      CMD_RESIZE     = 4'd4,
      CMD_COUNT      = 4'd5,
      CMD_READ       = 4'd6,
      CMD_READ_ALL   = 4'd7,
      CMD_SORTED     = 4'd8,
      CMD_SORTED_ALL = 4'd9
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 4'd0,
      ST_EXISTS     = 4'd1,
      ST_BAD_BIN    = 4'd2,
      ST_TOO_LARGE  = 4'd3,
      ST_BAD_SIZE   = 4'd4,
      ST_FULL       = 4'd5,
      ST_NO_BIN     = 4'd6,
      ST_EMPTY      = 4'd7,
      ST_NOT_FOUND  = 4'd8,
      ST_BAD_NEWSZ  = 4'd9,
      ST_ALL_EMPTY  = 4'd10
   } status_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_DECIDE,
      CS_WALK_RD,
      CS_WALK_USE,
      CS_WALK_END,
      CS_SHIFT_RD,
      CS_SHIFT_WR
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic apply;
      logic walk_rd;
      logic walk_use;
      logic pass_next;
      logic finish;
      logic shift_rd;
      logic shift_wr;
      logic remove_done;
   } blte_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic dec_none;
      logic dec_walk;
      logic pos_valid;
      logic more_bins;
      logic is_remove;
      logic match;
      logic sorted;
      logic have_best;
      logic sh_more;
      logic out_free;
   } blte_stat_type;

endpackage

// ===== hw/rtl/blte_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bounded list table engine controller
// Sequences decode, list walks, sort passes and remove shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blte_ctrl
   import blte_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  blte_stat_type stat,
   output blte_cmd_type  cmd
);

   ctl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != CS_IDLE);
      case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CS_DECIDE;
            end
         end
         CS_DECIDE: begin
            if (stat.dec_none) begin
               state_in = CS_IDLE;
            end else if (stat.dec_walk) begin
               state_in = CS_WALK_RD;
            end else if (stat.out_free) begin
               cmd.apply = 1'b1;
               state_in  = CS_IDLE;
            end
         end
         CS_WALK_RD: begin
            cmd.walk_rd = 1'b1;
            if (stat.pos_valid) begin
               state_in = CS_WALK_USE;
            end else if (!stat.more_bins) begin
               state_in = CS_WALK_END;
            end
         end
         CS_WALK_USE: begin
            if (stat.out_free) begin
               cmd.walk_use = 1'b1;
               if (stat.is_remove && stat.match) begin
                  state_in = CS_SHIFT_RD;
               end else begin
                  state_in = CS_WALK_RD;
               end
            end
         end
         CS_WALK_END: begin
            if (stat.out_free) begin
               if (stat.sorted && stat.have_best) begin
                  cmd.pass_next = 1'b1;
                  state_in      = CS_WALK_RD;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = CS_IDLE;
               end
            end
         end
         CS_SHIFT_RD: begin
            if (stat.sh_more) begin
               cmd.shift_rd = 1'b1;
               state_in     = CS_SHIFT_WR;
            end else if (stat.out_free) begin
               cmd.remove_done = 1'b1;
               state_in        = CS_IDLE;
            end
         end
         CS_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = CS_SHIFT_RD;
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/blte_datapath.sv =====
// ----------------------------------------------------------------------------
// Bounded list table engine datapath
// Bin table, entry memory, walk position, sort keys and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bounded_list_table_engine_top_assert.svh"

module blte_datapath
   import blte_pkg::*;
#(
   parameter int NUM_BINS  = NUM_BINS_DEF,
   parameter int BIN_DEPTH = BIN_DEPTH_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic [BIN_F_W-1:0]         req_bin,
   input  logic signed [AMOUNT_W-1:0] req_amount,
   input  logic signed [WORD_W-1:0]   req_value,
   input  blte_cmd_type               cmd,
   output blte_stat_type              stat,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [WORD_W-1:0]   rsp_data,
   output logic [COUNT_W-1:0]         rsp_count,
   output logic                       rsp_last
);

   localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int IDX_W = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
   localparam int CNT_W = $clog2(BIN_DEPTH + 1);
   localparam int ADDR_W = BIN_W + IDX_W;
   localparam int MEM_DEPTH = NUM_BINS << IDX_W;

   // bin table
   logic             bin_exists_ff   [NUM_BINS];
   logic [CNT_W-1:0] bin_capacity_ff [NUM_BINS];
   logic [CNT_W-1:0] bin_count_ff    [NUM_BINS];

   // entry memory
   logic [WORD_W-1:0] entry_mem [MEM_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   // latched command
   logic [CMD_W-1:0]           cmd_ff;
   logic                       bin_ok_ff;
   logic signed [AMOUNT_W-1:0] amount_ff;
   logic signed [WORD_W-1:0]   value_ff;

   // walk position and sort keys
   logic [BIN_W-1:0]         cur_bin_ff;
   logic [CNT_W-1:0]         cur_idx_ff;
   logic [CNT_W-1:0]         sh_idx_ff;
   logic                     have_pend_ff, have_prev_ff, have_best_ff;
   logic signed [WORD_W-1:0] pend_ff, prev_v_ff, best_v_ff;
   logic [ADDR_W-1:0]        prev_pos_ff, best_pos_ff;

   // result register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [WORD_W-1:0]   rsp_data_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_last_ff;

   logic                out_free;
   logic                push;
   status_type          push_st;
   logic [WORD_W-1:0]   push_data;
   logic [COUNT_W-1:0]  push_cnt;
   logic                push_last;

   logic                cur_ex;
   logic [CNT_W-1:0]    cur_cap, cur_cnt;
   logic                all_mode, sorted_mode, remove_mode;
   logic signed [7:0]   amt8, newcap;
   logic                dec_none, dec_walk;
   status_type          dec_st;
   logic [COUNT_W-1:0]  dec_cnt;
   logic                upd_create, upd_resize, upd_append, upd_drop;
   logic                pos_valid, more_bins;
   logic [ADDR_W-1:0]   cur_pos;
   logic signed [WORD_W-1:0] cand;
   logic                gt_prev, lt_best;
   logic                rd_en, wr_en;
   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic [WORD_W-1:0]   wr_data;
   logic                load_ok;

   assign cur_ex   = bin_exists_ff[cur_bin_ff];
   assign cur_cap  = bin_capacity_ff[cur_bin_ff];
   assign cur_cnt  = bin_count_ff[cur_bin_ff];
   assign all_mode    = (cmd_ff == CMD_READ_ALL) || (cmd_ff == CMD_SORTED_ALL);
   assign sorted_mode = (cmd_ff == CMD_SORTED) || (cmd_ff == CMD_SORTED_ALL);
   assign remove_mode = (cmd_ff == CMD_REMOVE);
   assign amt8   = {{2{amount_ff[AMOUNT_W-1]}}, amount_ff};
   assign newcap = (cur_ex ? $signed({1'b0, 7'(cur_cap)}) : 8'sd0) + amt8;
   assign load_ok = (req_bin >= BIN_F_W'(1)) && (5'(req_bin) <= 5'(NUM_BINS));

   // command decode against the selected bin
   always_comb begin
      dec_none   = 1'b0;
      dec_walk   = 1'b0;
      dec_st     = ST_OK;
      dec_cnt    = '0;
      upd_create = 1'b0;
      upd_resize = 1'b0;
      upd_append = 1'b0;
      upd_drop   = 1'b0;
      case (cmd_ff)
         CMD_CREATE: begin
            if (amt8 < 8'sd1) dec_st = ST_BAD_SIZE;
            else if (amt8 > $signed(8'(BIN_DEPTH))) dec_st = ST_TOO_LARGE;
            else if (!bin_ok_ff) dec_st = ST_BAD_BIN;
            else if (cur_ex) dec_st = ST_EXISTS;
            else upd_create = 1'b1;
         end
         CMD_RESIZE: begin
            if (!bin_ok_ff) dec_st = ST_BAD_BIN;
            else if (newcap < 8'sd1) dec_st = ST_BAD_NEWSZ;
            else if (newcap > $signed(8'(BIN_DEPTH))) dec_st = ST_TOO_LARGE;
            else if (!cur_ex) dec_st = ST_NO_BIN;
            else upd_resize = 1'b1;
         end
         CMD_READ_ALL, CMD_SORTED_ALL: begin
            dec_walk = 1'b1;
         end
         CMD_APPEND, CMD_DROP, CMD_REMOVE, CMD_COUNT, CMD_READ, CMD_SORTED: begin
            if (!bin_ok_ff) dec_st = ST_BAD_BIN;
            else if (!cur_ex) dec_st = ST_NO_BIN;
            else if (cmd_ff == CMD_APPEND) begin
               if (cur_cnt >= cur_cap || 32'(cur_cnt) >= BIN_DEPTH) dec_st = ST_FULL;
               else upd_append = 1'b1;
            end else if (cur_cnt == '0) dec_st = ST_EMPTY;
            else if (cmd_ff == CMD_DROP) upd_drop = 1'b1;
            else if (cmd_ff == CMD_COUNT) dec_cnt = COUNT_W'(cur_cnt);
            else dec_walk = 1'b1;
         end
         default: begin
            dec_none = 1'b1;
         end
      endcase
   end

   // walk position and sort key compare
   assign pos_valid = cur_ex && (cur_idx_ff < cur_cnt);
   assign more_bins = all_mode && (cur_bin_ff != BIN_W'(NUM_BINS - 1));
   assign cur_pos   = {cur_bin_ff, cur_idx_ff[IDX_W-1:0]};
   assign cand      = $signed(rd_data_ff);
   assign gt_prev   = !have_prev_ff || (cand > prev_v_ff) ||
                      ((cand == prev_v_ff) && (cur_pos > prev_pos_ff));
   assign lt_best   = !have_best_ff || (cand < best_v_ff) ||
                      ((cand == best_v_ff) && (cur_pos < best_pos_ff));

   assign stat.dec_none  = dec_none;
   assign stat.dec_walk  = dec_walk;
   assign stat.pos_valid = pos_valid;
   assign stat.more_bins = more_bins;
   assign stat.is_remove = remove_mode;
   assign stat.match     = (cand == value_ff);
   assign stat.sorted    = sorted_mode;
   assign stat.have_best = have_best_ff;
   assign stat.sh_more   = (sh_idx_ff + CNT_W'(1)) < cur_cnt;
   assign stat.out_free  = out_free;

   // result selection
   assign out_free = !rsp_valid_ff || !rsp_stall;
   always_comb begin
      push      = 1'b0;
      push_st   = ST_OK;
      push_data = '0;
      push_cnt  = '0;
      push_last = 1'b1;
      if (cmd.apply) begin
         push     = 1'b1;
         push_st  = dec_st;
         push_cnt = dec_cnt;
      end else if (cmd.walk_use) begin
         if (!sorted_mode && !remove_mode && have_pend_ff) begin
            push      = 1'b1;
            push_data = pend_ff;
            push_last = 1'b0;
         end
      end else if (cmd.pass_next) begin
         push      = have_pend_ff;
         push_data = pend_ff;
         push_last = 1'b0;
      end else if (cmd.finish) begin
         push = 1'b1;
         if (have_pend_ff) push_data = pend_ff;
         else if (remove_mode) push_st = ST_NOT_FOUND;
         else push_st = ST_ALL_EMPTY;
      end else if (cmd.remove_done) begin
         push = 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_status_ff <= push_st;
         rsp_data_ff   <= push_data;
         rsp_count_ff  <= push_cnt;
         rsp_last_ff   <= push_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = $signed(rsp_data_ff);
   assign rsp_count  = rsp_count_ff;
   assign rsp_last   = rsp_last_ff;

   // bin table updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            bin_exists_ff[i]   <= 1'b0;
            bin_capacity_ff[i] <= '0;
            bin_count_ff[i]    <= '0;
         end
      end else begin
         if (cmd.apply && upd_create) begin
            bin_exists_ff[cur_bin_ff]   <= 1'b1;
            bin_capacity_ff[cur_bin_ff] <= CNT_W'(amount_ff);
            bin_count_ff[cur_bin_ff]    <= '0;
         end
         if (cmd.apply && upd_resize) begin
            bin_capacity_ff[cur_bin_ff] <= CNT_W'(newcap);
            if (cur_cnt > CNT_W'(newcap)) bin_count_ff[cur_bin_ff] <= CNT_W'(newcap);
         end
         if (cmd.apply && upd_append) bin_count_ff[cur_bin_ff] <= cur_cnt + CNT_W'(1);
         if ((cmd.apply && upd_drop) || cmd.remove_done) begin
            bin_count_ff[cur_bin_ff] <= cur_cnt - CNT_W'(1);
         end
      end
   end

   // latched command and walk state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_bin_ff   <= '0;
         cur_idx_ff   <= '0;
         have_pend_ff <= 1'b0;
         have_prev_ff <= 1'b0;
         have_best_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            cmd_ff       <= req_cmd;
            bin_ok_ff    <= load_ok;
            amount_ff    <= req_amount;
            value_ff     <= req_value;
            cur_bin_ff   <= (load_ok && (req_cmd != CMD_READ_ALL) &&
                            (req_cmd != CMD_SORTED_ALL)) ?
                            BIN_W'(req_bin - BIN_F_W'(1)) : '0;
            cur_idx_ff   <= '0;
            have_pend_ff <= 1'b0;
            have_prev_ff <= 1'b0;
            have_best_ff <= 1'b0;
         end
         if (cmd.walk_rd && !pos_valid && more_bins) begin
            cur_bin_ff <= cur_bin_ff + BIN_W'(1);
            cur_idx_ff <= '0;
         end
         if (cmd.walk_use) begin
            cur_idx_ff <= cur_idx_ff + CNT_W'(1);
            if (sorted_mode) begin
               if (gt_prev && lt_best) begin
                  have_best_ff <= 1'b1;
                  best_v_ff    <= cand;
                  best_pos_ff  <= cur_pos;
               end
            end else if (remove_mode) begin
               sh_idx_ff <= cur_idx_ff;
            end else begin
               have_pend_ff <= 1'b1;
               pend_ff      <= cand;
            end
         end
         if (cmd.pass_next) begin
            have_pend_ff <= 1'b1;
            pend_ff      <= best_v_ff;
            have_prev_ff <= 1'b1;
            prev_v_ff    <= best_v_ff;
            prev_pos_ff  <= best_pos_ff;
            have_best_ff <= 1'b0;
            cur_idx_ff   <= '0;
            if (all_mode) cur_bin_ff <= '0;
         end
         if (cmd.shift_wr) sh_idx_ff <= sh_idx_ff + CNT_W'(1);
      end
   end

   // memory port selection
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = cur_pos;
      wr_en   = 1'b0;
      wr_addr = {cur_bin_ff, cur_cnt[IDX_W-1:0]};
      wr_data = value_ff;
      if (cmd.walk_rd && pos_valid) begin
         rd_en = 1'b1;
      end
      if (cmd.shift_rd) begin
         rd_en   = 1'b1;
         rd_addr = {cur_bin_ff, IDX_W'(sh_idx_ff + CNT_W'(1))};
      end
      if (cmd.apply && upd_append) begin
         wr_en = 1'b1;
      end
      if (cmd.shift_wr) begin
         wr_en   = 1'b1;
         wr_addr = {cur_bin_ff, sh_idx_ff[IDX_W-1:0]};
         wr_data = rd_data_ff;
      end
   end

   // entry memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= entry_mem[rd_addr];
   end

   `BLTE_ASSERT(a_push_free, push |-> out_free, "result pushed while output is held")
   `BLTE_ASSERT(a_err_last, rsp_valid_ff && (rsp_status_ff != ST_OK) |-> rsp_last_ff, "error item without last")
   `BLTE_ASSERT(a_remove_cnt, cmd.remove_done |-> (cur_cnt != '0), "remove finished on empty bin")
   `BLTE_ASSERT(a_cnt_cap, cur_ex |-> (cur_cnt <= cur_cap), "bin count above capacity")

endmodule

// ===== hw/rtl/bounded_list_table_engine_top.sv =====
// Single-item commands are latched at the transfer, decoded, and put in the output register once it is free.
// Read/read all: each stored entry is fetched through the registered memory read port, then passed on.
// Sorted reads: n+1 selection passes, each walking every stored entry of the bins visited.
// Remove: searches the entries in order, then shifts each later entry down, a read then a write each.
// One command at a time; reset clears the bin table and output valid flag, entry memory is not cleared.
// ----------------------------------------------------------------------------
// Bounded list table engine top
// Table of bins, each a bounded ordered list of signed words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_list_table_engine_top
   import blte_pkg::*;
#(
   parameter int NUM_BINS  = NUM_BINS_DEF,
   parameter int BIN_DEPTH = BIN_DEPTH_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic [BIN_F_W-1:0]         req_bin,
   input  logic signed [AMOUNT_W-1:0] req_amount,
   input  logic signed [WORD_W-1:0]   req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [WORD_W-1:0]   rsp_data,
   output logic [COUNT_W-1:0]         rsp_count,
   output logic                       rsp_last
);

   blte_cmd_type  cmd;
   blte_stat_type stat;

   // sequencer
   blte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage and result path
   blte_datapath #(
      .NUM_BINS  (NUM_BINS),
      .BIN_DEPTH (BIN_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_cmd    (req_cmd),
      .req_bin    (req_bin),
      .req_amount (req_amount),
      .req_value  (req_value),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_count  (rsp_count),
      .rsp_last   (rsp_last)
   );

endmodule

// ===== test/bounded_list_table_engine_top_tb.sv =====
// ----------------------------------------------------------------------------
// Bounded list table engine testbench
// Drives command transfers with random gaps and checks every response
// transfer against a behavioral table of bins kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_list_table_engine_top_tb;
   import blte_pkg::*;

   localparam int NBINS = NUM_BINS_DEF;
   localparam int DEPTH = BIN_DEPTH_DEF;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   data;
      logic [COUNT_W-1:0]  count;
      logic                last;
   } rsp_item_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [CMD_W-1:0] req_cmd;
   logic [BIN_F_W-1:0] req_bin;
   logic signed [AMOUNT_W-1:0] req_amount;
   logic signed [WORD_W-1:0] req_value;
   logic rsp_valid;
   logic rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic signed [WORD_W-1:0] rsp_data;
   logic [COUNT_W-1:0] rsp_count;
   logic rsp_last;

   // bench copy of the bin table
   logic [WORD_W-1:0] words_q [NBINS][DEPTH];
   logic              live_q [NBINS];
   int                cap_q [NBINS];
   int                fill_q [NBINS];

   rsp_item_type expected_rsps [$];
   int  error_count;
   int  idle_cycles;
   bit  stim_done;

   bounded_list_table_engine_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_cmd), .req_bin(req_bin),
      .req_amount(req_amount), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_data(rsp_data),
      .rsp_count(rsp_count), .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(1, 3);
   endfunction

   function automatic void push_one(status_type st, int cnt);
      rsp_item_type r;
      r.status = st;
      r.data = '0;
      r.count = cnt[COUNT_W-1:0];
      r.last = 1'b1;
      expected_rsps.push_back(r);
   endfunction

   function automatic void push_words(logic [WORD_W-1:0] w [$], bit sorted);
      rsp_item_type r;
      logic [WORD_W-1:0] t;
      // insertion sort, signed compare
      if (sorted)
         for (int i = 1; i < w.size(); i++)
            for (int j = i; j > 0 && $signed(w[j-1]) > $signed(w[j]); j--) begin
               t = w[j]; w[j] = w[j-1]; w[j-1] = t;
            end
      foreach (w[k]) begin
         r.status = ST_OK;
         r.data = w[k];
         r.count = '0;
         r.last = (k == w.size() - 1);
         expected_rsps.push_back(r);
      end
   endfunction

   // predict responses of one command and update the bench table
   function automatic void predict_command(logic [CMD_W-1:0] cmd, logic [BIN_F_W-1:0] binf,
                                           logic signed [AMOUNT_W-1:0] amt,
                                           logic [WORD_W-1:0] val);
      int amount;
      int b;
      int newcap;
      bit ok;
      logic [WORD_W-1:0] w [$];
      amount = amt;
      ok = binf >= 1 && binf <= NBINS;
      b = ok ? binf - 1 : 0;
      if (cmd > CMD_SORTED_ALL) return;
      case (cmd)
         CMD_CREATE: begin
            if (amount < 1) push_one(ST_BAD_SIZE, 0);
            else if (amount > DEPTH) push_one(ST_TOO_LARGE, 0);
            else if (!ok) push_one(ST_BAD_BIN, 0);
            else if (live_q[b]) push_one(ST_EXISTS, 0);
            else begin
               live_q[b] = 1; cap_q[b] = amount; fill_q[b] = 0;
               push_one(ST_OK, 0);
            end
            return;
         end
         CMD_RESIZE: begin
            if (!ok) begin push_one(ST_BAD_BIN, 0); return; end
            newcap = (live_q[b] ? cap_q[b] : 0) + amount;
            if (newcap < 1) push_one(ST_BAD_NEWSZ, 0);
            else if (newcap > DEPTH) push_one(ST_TOO_LARGE, 0);
            else if (!live_q[b]) push_one(ST_NO_BIN, 0);
            else begin
               cap_q[b] = newcap;
               if (fill_q[b] > newcap) fill_q[b] = newcap;
               push_one(ST_OK, 0);
            end
            return;
         end
         CMD_READ_ALL, CMD_SORTED_ALL: begin
            for (int i = 0; i < NBINS; i++)
               if (live_q[i])
                  for (int j = 0; j < fill_q[i]; j++) w.push_back(words_q[i][j]);
            if (w.size() == 0) push_one(ST_ALL_EMPTY, 0);
            else push_words(w, cmd == CMD_SORTED_ALL);
            return;
         end
         default: ;
      endcase
      if (!ok) begin push_one(ST_BAD_BIN, 0); return; end
      if (!live_q[b]) begin push_one(ST_NO_BIN, 0); return; end
      if (cmd == CMD_APPEND) begin
         if (fill_q[b] >= cap_q[b]) push_one(ST_FULL, 0);
         else begin
            words_q[b][fill_q[b]] = val; fill_q[b]++;
            push_one(ST_OK, 0);
         end
         return;
      end
      if (fill_q[b] == 0) begin push_one(ST_EMPTY, 0); return; end
      case (cmd)
         CMD_DROP: begin fill_q[b]--; push_one(ST_OK, 0); end
         CMD_REMOVE: begin
            for (int i = 0; i < fill_q[b]; i++)
               if (words_q[b][i] == val) begin
                  for (int j = i; j + 1 < fill_q[b]; j++) words_q[b][j] = words_q[b][j+1];
                  fill_q[b]--;
                  push_one(ST_OK, 0);
                  return;
               end
            push_one(ST_NOT_FOUND, 0);
         end
         CMD_COUNT: push_one(ST_OK, fill_q[b]);
         default: begin
            for (int j = 0; j < fill_q[b]; j++) w.push_back(words_q[b][j]);
            push_words(w, cmd == CMD_SORTED);
         end
      endcase
   endfunction

   // one command transfer, preceded by a random gap; valid stays high
   // across back to back transfers and drops only during a gap
   task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [BIN_F_W-1:0] binf,
                           logic signed [AMOUNT_W-1:0] amt, logic [WORD_W-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_bin <= binf;
      req_amount <= amt;
      req_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_command(cmd, binf, amt, val);
   endtask

   // response stall generator
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         n = pick_gap();
         rsp_stall <= (n != 0);
         repeat (n == 0 ? $urandom_range(1, 20) : n) @(posedge clock);
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response status=%0d data=%0d", $time,
                     rsp_status, rsp_data);
            error_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_status !== e.status || rsp_data !== e.data ||
                rsp_count !== e.count || rsp_last !== e.last) begin
               $display("%0t: mismatch exp status=%0d data=%0d count=%0d last=%0d",
                        $time, e.status, $signed(e.data), e.count, e.last);
               $display("%0t:          act status=%0d data=%0d count=%0d last=%0d",
                        $time, rsp_status, rsp_data, rsp_count, rsp_last);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("bounded_list_table_engine_top_tb: errors");
         $finish;
      end
   end

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 7) - 3;
         default: return $urandom;
      endcase
   endfunction

   // every code path of create, resize and the error checks
   task automatic test_directed();
      send_cmd(CMD_READ_ALL, 1, 0, 0);
      send_cmd(CMD_SORTED_ALL, 1, 0, 0);
      send_cmd(CMD_CREATE, 1, 0, 0);
      send_cmd(CMD_CREATE, 1, -16, 0);
      send_cmd(CMD_CREATE, 1, 16, 0);
      send_cmd(CMD_CREATE, 0, 8, 0);
      send_cmd(CMD_CREATE, 15, 8, 0);
      send_cmd(CMD_APPEND, 2, 0, 1);
      send_cmd(CMD_RESIZE, 9, 1, 0);
      send_cmd(CMD_RESIZE, 2, 3, 0);
      send_cmd(CMD_RESIZE, 2, -1, 0);
      send_cmd(CMD_CREATE, 1, 2, 0);
      send_cmd(CMD_CREATE, 1, 2, 0);
      send_cmd(CMD_DROP, 1, 0, 0);
      send_cmd(CMD_READ, 1, 0, 0);
      send_cmd(CMD_APPEND, 1, 0, 32'h7fff_ffff);
      send_cmd(CMD_APPEND, 1, 0, 32'h8000_0000);
      send_cmd(CMD_APPEND, 1, 0, 5);
      send_cmd(CMD_SORTED, 1, 0, 0);
      send_cmd(CMD_REMOVE, 1, 0, 9);
      send_cmd(CMD_RESIZE, 1, 16, 0);
      send_cmd(CMD_RESIZE, 1, -1, 0);
      send_cmd(CMD_COUNT, 1, 0, 0);
      send_cmd(CMD_REMOVE, 1, 0, 32'h7fff_ffff);
      send_cmd(4'd12, 1, 0, 0);
   endtask

   // random command mix: mostly valid bins, with appends weighted up
   task automatic test_random(int items);
      logic [CMD_W-1:0] c;
      logic [BIN_F_W-1:0] bn;
      logic signed [AMOUNT_W-1:0] a;
      int r;
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 30) c = CMD_APPEND;
         else if (r < 95) c = $urandom_range(0, 9);
         else c = $urandom_range(10, 15);
         bn = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, NBINS);
         a = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 20) - 10;
         send_cmd(c, bn, a, rand_word());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = '0;
      req_bin = '0;
      req_amount = '0;
      req_value = '0;
      error_count = 0;
      foreach (live_q[i]) begin live_q[i] = 0; cap_q[i] = 0; fill_q[i] = 0; end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(305);
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0)
         $display("bounded_list_table_engine_top_tb: clean");
      else
         $display("bounded_list_table_engine_top_tb: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/blte_pkg.sv
hw/rtl/blte_ctrl.sv
hw/rtl/blte_datapath.sv
hw/rtl/bounded_list_table_engine_top.sv
test/bounded_list_table_engine_top_tb.sv
